// File: hdl/jkse_pkg.sv
// ----------------------------------------------------------------------------
// jkse_pkg
// Types, constants and helper functions shared by the key string extractor.
// ----------------------------------------------------------------------------
package jkse_pkg;

  localparam int MAX_KEY_LEN = 8;
  localparam int WIN_DEPTH   = MAX_KEY_LEN + 2;
  localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
  localparam int KEY_LEN_W   = 4;
  localparam int KEY_W       = 8 * MAX_KEY_LEN;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 4;

  localparam logic [CFG_ADDR_W-1:0] ADDR_KEY_CHARS  = 4'h0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_KEY_LENGTH = 4'h8;

  localparam logic [7:0] CHR_COLON  = 8'h3A;
  localparam logic [7:0] CHR_QUOTE  = 8'h22;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_TAB    = 8'h09;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_FF     = 8'h0C;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_BS     = 8'h08;
  localparam logic [7:0] CHR_LOW_B  = 8'h62;
  localparam logic [7:0] CHR_LOW_F  = 8'h66;
  localparam logic [7:0] CHR_LOW_N  = 8'h6E;
  localparam logic [7:0] CHR_LOW_R  = 8'h72;
  localparam logic [7:0] CHR_LOW_T  = 8'h74;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_COLON  = 3'd1,
    PH_BLANK  = 3'd2,
    PH_STRING = 3'd3,
    PH_IDLE   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_KEY       = 3'd1,
    ST_NO_COLON     = 3'd2,
    ST_NOT_STRING   = 3'd3,
    ST_UNTERMINATED = 3'd4
  } status_t;

  typedef struct packed {
    logic       vld;
    logic       has_byte;
    logic [7:0] value_byte;
    logic       finished;
    status_t    status;
  } result_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == CHR_SPACE) || ((c >= CHR_TAB) && (c <= CHR_CR));
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    case (c)
      CHR_LOW_B: unescape = CHR_BS;
      CHR_LOW_F: unescape = CHR_FF;
      CHR_LOW_N: unescape = CHR_LF;
      CHR_LOW_R: unescape = CHR_CR;
      CHR_LOW_T: unescape = CHR_TAB;
      default:   unescape = c;
    endcase
  endfunction

endpackage

// File: hdl/jkse_window.sv
// ----------------------------------------------------------------------------
// jkse_window
// Sliding byte window with a parallel compare against the quoted key.
// ----------------------------------------------------------------------------
module jkse_window (
  input  logic                          clk,
  input  logic                          rst_n,
  input  jkse_pkg::win_ctl_t            ctl,
  input  logic [7:0]                    doc_byte,
  input  logic [jkse_pkg::KEY_W-1:0]    key_chars,
  input  logic [jkse_pkg::KEY_LEN_W-1:0] key_length,
  output logic                          match
);

  logic [7:0]                  win_r   [jkse_pkg::WIN_DEPTH];
  logic [7:0]                  win_new [jkse_pkg::WIN_DEPTH];
  logic [jkse_pkg::FILL_W-1:0] fill_r;
  logic [jkse_pkg::FILL_W-1:0] fill_nxt;
  logic [jkse_pkg::KEY_LEN_W-1:0] klen;
  logic [jkse_pkg::MAX_KEY_LEN:0] cand;

  always_comb begin
    win_new[0] = doc_byte;
    for (int j = 1; j < jkse_pkg::WIN_DEPTH; j++) begin
      win_new[j] = win_r[j-1];
    end
    fill_nxt = (fill_r == jkse_pkg::FILL_W'(jkse_pkg::WIN_DEPTH)) ? fill_r
                                                                  : fill_r + 1'b1;
    klen = (key_length > jkse_pkg::KEY_LEN_W'(jkse_pkg::MAX_KEY_LEN))
         ? jkse_pkg::KEY_LEN_W'(jkse_pkg::MAX_KEY_LEN) : key_length;
    for (int kk = 0; kk <= jkse_pkg::MAX_KEY_LEN; kk++) begin
      cand[kk] = (fill_nxt >= jkse_pkg::FILL_W'(kk + 2))
              && (win_new[0] == jkse_pkg::CHR_QUOTE)
              && (win_new[kk+1] == jkse_pkg::CHR_QUOTE);
      for (int i = 0; i < jkse_pkg::MAX_KEY_LEN; i++) begin
        if (i < kk) begin
          cand[kk] = cand[kk] && (win_new[kk-i] == key_chars[8*i +: 8]);
        end
      end
    end
    match = cand[klen];
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int j = 0; j < jkse_pkg::WIN_DEPTH; j++) begin
        win_r[j] <= win_new[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (ctl.clear) begin
      fill_r <= '0;
    end else if (ctl.shift) begin
      fill_r <= fill_nxt;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= jkse_pkg::FILL_W'(jkse_pkg::WIN_DEPTH))
    else $error("window fill count exceeds window depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> fill_r == '0)
    else $error("window not emptied at end of document");

  a_match_needs_quote: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.shift && match |-> doc_byte == jkse_pkg::CHR_QUOTE)
    else $error("key match without closing quote");

endmodule

// File: hdl/jkse_parser.sv
// ----------------------------------------------------------------------------
// jkse_parser
// Phase machine that finds the colon and the string, unescapes its bytes and
// forms the result of each document byte.
// ----------------------------------------------------------------------------
module jkse_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           doc_byte,
  input  logic                 doc_end,
  input  logic                 match,
  output jkse_pkg::win_ctl_t   win_ctl,
  output jkse_pkg::result_t    res
);

  jkse_pkg::phase_t phase_r;
  jkse_pkg::phase_t phase_nxt;
  logic             esc_r;
  logic             esc_nxt;

  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    unique case (phase_r)
      jkse_pkg::PH_SEARCH: begin
        if (match) begin
          phase_nxt = jkse_pkg::PH_COLON;
        end
      end
      jkse_pkg::PH_COLON: begin
        if (doc_byte == jkse_pkg::CHR_COLON) begin
          phase_nxt = jkse_pkg::PH_BLANK;
        end
      end
      jkse_pkg::PH_BLANK: begin
        if (doc_byte == jkse_pkg::CHR_QUOTE) begin
          phase_nxt = jkse_pkg::PH_STRING;
          esc_nxt   = 1'b0;
        end else if (!jkse_pkg::is_blank(doc_byte)) begin
          phase_nxt = jkse_pkg::PH_IDLE;
        end
      end
      jkse_pkg::PH_STRING: begin
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (doc_byte == jkse_pkg::CHR_BSLASH) begin
          esc_nxt = 1'b1;
        end else if (doc_byte == jkse_pkg::CHR_QUOTE) begin
          phase_nxt = jkse_pkg::PH_IDLE;
        end
      end
      jkse_pkg::PH_IDLE: begin
        phase_nxt = phase_r;
      end
      default: begin
        phase_nxt = jkse_pkg::PH_SEARCH;
      end
    endcase
    if (doc_end) begin
      phase_nxt = jkse_pkg::PH_SEARCH;
      esc_nxt   = 1'b0;
    end
  end

  always_comb begin
    res            = '0;
    res.status     = jkse_pkg::ST_OK;
    win_ctl.shift  = step && (phase_r == jkse_pkg::PH_SEARCH);
    win_ctl.clear  = step && doc_end;
    unique case (phase_r)
      jkse_pkg::PH_SEARCH: begin
        if (doc_end) begin
          res.vld      = 1'b1;
          res.finished = 1'b1;
          res.status   = match ? jkse_pkg::ST_NO_COLON : jkse_pkg::ST_NO_KEY;
        end
      end
      jkse_pkg::PH_COLON: begin
        if (doc_end) begin
          res.vld      = 1'b1;
          res.finished = 1'b1;
          res.status   = (doc_byte == jkse_pkg::CHR_COLON) ? jkse_pkg::ST_NOT_STRING
                                                           : jkse_pkg::ST_NO_COLON;
        end
      end
      jkse_pkg::PH_BLANK: begin
        if (doc_byte == jkse_pkg::CHR_QUOTE) begin
          if (doc_end) begin
            res.vld      = 1'b1;
            res.finished = 1'b1;
            res.status   = jkse_pkg::ST_UNTERMINATED;
          end
        end else if (!jkse_pkg::is_blank(doc_byte) || doc_end) begin
          res.vld      = 1'b1;
          res.finished = 1'b1;
          res.status   = jkse_pkg::ST_NOT_STRING;
        end
      end
      jkse_pkg::PH_STRING: begin
        if (!esc_r && (doc_byte == jkse_pkg::CHR_QUOTE)) begin
          res.vld      = 1'b1;
          res.finished = 1'b1;
        end else if (doc_end) begin
          res.vld      = 1'b1;
          res.finished = 1'b1;
          res.status   = jkse_pkg::ST_UNTERMINATED;
        end else if (esc_r) begin
          res.vld        = 1'b1;
          res.has_byte   = 1'b1;
          res.value_byte = jkse_pkg::unescape(doc_byte);
        end else if (doc_byte != jkse_pkg::CHR_BSLASH) begin
          res.vld        = 1'b1;
          res.has_byte   = 1'b1;
          res.value_byte = doc_byte;
        end
      end
      jkse_pkg::PH_IDLE: begin
        res.vld = 1'b0;
      end
      default: begin
        res.vld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jkse_pkg::PH_SEARCH;
      esc_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
    end
  end

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    step && doc_end |=> phase_r == jkse_pkg::PH_SEARCH && !esc_r)
    else $error("parser did not rearm after end of document");

  a_esc_in_string: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> phase_r == jkse_pkg::PH_STRING)
    else $error("escape pending outside a string");

  a_byte_in_string: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld && res.has_byte |-> phase_r == jkse_pkg::PH_STRING && !doc_end)
    else $error("string byte emitted outside a string");

endmodule

// File: hdl/json_key_string_extractor.sv
// ----------------------------------------------------------------------------
// json_key_string_extractor
// Finds a configured quoted key in a JSON byte stream and returns the
// unescaped bytes of its string value, followed by a status transaction.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// in_       slave      tdata = doc_byte, tlast = doc_end
// out_      master     tdata = value_byte, tuser = has_byte, status;
//                      tlast = finished
// cfg_      APB slave  key_chars at 0x0, key_length at 0x8
//
// One byte is accepted per cycle while out_ does not stall; each byte passes
// the input register and then the result register. These each hold one
// transaction, so one new byte can be taken while a result waits for out_tready.
// Bytes that give no result pass through without any output transaction.
// Reset is synchronous; it clears the phase, the window fill and both valids.
// ----------------------------------------------------------------------------
module json_key_string_extractor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] doc_byte
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // [7:0] value_byte
  output logic [3:0]                      out_tuser,  // [0] has_byte, [3:1] status
  output logic                            out_tlast,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [jkse_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [jkse_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [jkse_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  logic [jkse_pkg::KEY_W-1:0]     key_chars_r;
  logic [jkse_pkg::KEY_LEN_W-1:0] key_length_r;
  logic                           cfg_wr;

  logic                           in_vld_r;
  logic [7:0]                     in_byte_r;
  logic                           in_last_r;
  logic                           adv;

  logic                           match;
  jkse_pkg::win_ctl_t             win_ctl;
  jkse_pkg::result_t              res;

  logic                           out_vld_r;
  jkse_pkg::result_t              out_res_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_chars_r  <= '0;
      key_length_r <= jkse_pkg::KEY_LEN_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_paddr)
        jkse_pkg::ADDR_KEY_CHARS:  key_chars_r  <= cfg_pwdata[jkse_pkg::KEY_W-1:0];
        jkse_pkg::ADDR_KEY_LENGTH: key_length_r <= cfg_pwdata[jkse_pkg::KEY_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      jkse_pkg::ADDR_KEY_CHARS:  cfg_prdata = jkse_pkg::CFG_DATA_W'(key_chars_r);
      jkse_pkg::ADDR_KEY_LENGTH: cfg_prdata = jkse_pkg::CFG_DATA_W'(key_length_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  jkse_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (win_ctl),
    .doc_byte   (in_byte_r),
    .key_chars  (key_chars_r),
    .key_length (key_length_r),
    .match      (match)
  );

  jkse_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .doc_byte (in_byte_r),
    .doc_end  (in_last_r),
    .match    (match),
    .win_ctl  (win_ctl),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= res.vld;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_res_r.value_byte;
  assign out_tuser  = {out_res_r.status, out_res_r.has_byte};
  assign out_tlast  = out_res_r.finished;

  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[3:1] == jkse_pkg::ST_OK && !out_tlast)
    else $error("string byte transaction carries a final status");

  a_nonfinal_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser[0])
    else $error("non-final transaction without a string byte");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_res_r))
    else $error("pending result overwritten while stalled");

endmodule

// File: tb/sv/json_key_string_extractor_test.sv
// ----------------------------------------------------------------------------
// json_key_string_extractor_test
// Self-checking bench for the JSON key string extractor. Documents are sent
// byte by byte on in_, each accepted byte runs through a local model of the
// key search, colon and blank handling and string unescaping, and every out_
// transaction is compared in order with the predicted value bytes and status.
// Keys are changed over APB between documents and once in mid-document.
// ----------------------------------------------------------------------------
module json_key_string_extractor_test;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic              has_byte;
    logic [7:0]        value_byte;
    logic              finished;
    jkse_pkg::status_t status;
  } value_result_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [7:0]                      in_tdata;
  logic                            in_tlast;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [7:0]                      out_tdata;
  logic [3:0]                      out_tuser;
  logic                            out_tlast;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [jkse_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [jkse_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [jkse_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  // Local copy of the block state and its key registers.
  jkse_pkg::phase_t                scan_phase;
  logic [7:0]                      recent_bytes [jkse_pkg::WIN_DEPTH];
  int unsigned                     recent_fill;
  logic                            in_escape;
  logic [jkse_pkg::KEY_W-1:0]      key_chars;
  logic [jkse_pkg::KEY_LEN_W-1:0]  key_len;

  value_result_t         expected_values [$];
  logic [7:0]            doc_q [$];
  int unsigned           mismatch_count;
  int unsigned           cycle_count;
  int unsigned           sender_idle_pct;
  int unsigned           sink_stall_pct;
  int unsigned           hold_req;
  int unsigned           hold_left;

  json_key_string_extractor i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  function automatic void rearm_scan();
    scan_phase  = jkse_pkg::PH_SEARCH;
    recent_fill = 0;
    in_escape   = 1'b0;
    for (int i = 0; i < jkse_pkg::WIN_DEPTH; i++) recent_bytes[i] = 8'h00;
  endfunction

  function automatic void expect_value(input logic has, input logic [7:0] val,
                                       input logic fin, input jkse_pkg::status_t st);
    value_result_t r;
    r.has_byte   = has;
    r.value_byte = val;
    r.finished   = fin;
    r.status     = st;
    expected_values = {expected_values, r};
  endfunction

  function automatic void add_byte(input logic [7:0] c);
    doc_q = {doc_q, c};
  endfunction

  function automatic logic quoted_key_seen(input logic [7:0] c);
    int unsigned k;
    int unsigned len;
    for (int i = jkse_pkg::WIN_DEPTH - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
    recent_bytes[0] = c;
    if (recent_fill < jkse_pkg::WIN_DEPTH) recent_fill++;
    k   = (key_len > jkse_pkg::MAX_KEY_LEN) ? jkse_pkg::MAX_KEY_LEN : key_len;
    len = k + 2;
    if (recent_fill < len) return 1'b0;
    if (recent_bytes[0] != jkse_pkg::CHR_QUOTE ||
        recent_bytes[len-1] != jkse_pkg::CHR_QUOTE) return 1'b0;
    for (int i = 0; i < k; i++) begin
      if (recent_bytes[len-2-i] != key_chars[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void extract_step(input logic [7:0] c, input logic last);
    logic [7:0] plain;
    logic       blank;
    blank = (c == jkse_pkg::CHR_SPACE) || (c >= jkse_pkg::CHR_TAB && c <= jkse_pkg::CHR_CR);
    case (c)
      jkse_pkg::CHR_LOW_B: plain = jkse_pkg::CHR_BS;
      jkse_pkg::CHR_LOW_F: plain = jkse_pkg::CHR_FF;
      jkse_pkg::CHR_LOW_N: plain = jkse_pkg::CHR_LF;
      jkse_pkg::CHR_LOW_R: plain = jkse_pkg::CHR_CR;
      jkse_pkg::CHR_LOW_T: plain = jkse_pkg::CHR_TAB;
      default:             plain = c;
    endcase
    case (scan_phase)
      jkse_pkg::PH_SEARCH: begin
        if (quoted_key_seen(c)) begin
          scan_phase = jkse_pkg::PH_COLON;
          if (last) expect_value(1'b0, 8'h00, 1'b1, jkse_pkg::ST_NO_COLON);
        end else if (last) begin
          expect_value(1'b0, 8'h00, 1'b1, jkse_pkg::ST_NO_KEY);
        end
      end
      jkse_pkg::PH_COLON: begin
        if (c == jkse_pkg::CHR_COLON) begin
          scan_phase = jkse_pkg::PH_BLANK;
          if (last) expect_value(1'b0, 8'h00, 1'b1, jkse_pkg::ST_NOT_STRING);
        end else if (last) begin
          expect_value(1'b0, 8'h00, 1'b1, jkse_pkg::ST_NO_COLON);
        end
      end
      jkse_pkg::PH_BLANK: begin
        if (c == jkse_pkg::CHR_QUOTE) begin
          scan_phase = jkse_pkg::PH_STRING;
          in_escape  = 1'b0;
          if (last) expect_value(1'b0, 8'h00, 1'b1, jkse_pkg::ST_UNTERMINATED);
        end else if (blank) begin
          if (last) expect_value(1'b0, 8'h00, 1'b1, jkse_pkg::ST_NOT_STRING);
        end else begin
          scan_phase = jkse_pkg::PH_IDLE;
          expect_value(1'b0, 8'h00, 1'b1, jkse_pkg::ST_NOT_STRING);
        end
      end
      jkse_pkg::PH_STRING: begin
        if (in_escape) begin
          in_escape = 1'b0;
          if (last) expect_value(1'b0, 8'h00, 1'b1, jkse_pkg::ST_UNTERMINATED);
          else expect_value(1'b1, plain, 1'b0, jkse_pkg::ST_OK);
        end else if (c == jkse_pkg::CHR_BSLASH) begin
          in_escape = 1'b1;
          if (last) expect_value(1'b0, 8'h00, 1'b1, jkse_pkg::ST_UNTERMINATED);
        end else if (c == jkse_pkg::CHR_QUOTE) begin
          scan_phase = jkse_pkg::PH_IDLE;
          expect_value(1'b0, 8'h00, 1'b1, jkse_pkg::ST_OK);
        end else if (last) begin
          expect_value(1'b0, 8'h00, 1'b1, jkse_pkg::ST_UNTERMINATED);
        end else begin
          expect_value(1'b1, c, 1'b0, jkse_pkg::ST_OK);
        end
      end
      default: begin
      end
    endcase
    if (last) rearm_scan();
  endfunction

  always @(posedge clk) begin : check_results
    value_result_t got;
    value_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.has_byte   = out_tuser[0];
      got.value_byte = out_tdata;
      got.finished   = out_tlast;
      got.status     = jkse_pkg::status_t'(out_tuser[3:1]);
      if (expected_values.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0d: unexpected transaction has=%b byte=%02h fin=%b status=%0d",
                   cycle_count, got.has_byte, got.value_byte, got.finished, got.status);
      end else begin
        want = expected_values.pop_front();
        if (got.has_byte !== want.has_byte || got.value_byte !== want.value_byte ||
            got.finished !== want.finished || got.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0d: expected %b/%02h/%b/%0d, got %b/%02h/%b/%0d",
                     cycle_count, want.has_byte, want.value_byte, want.finished,
                     want.status, got.has_byte, got.value_byte, got.finished, got.status);
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    extract_step(b, last);
    @(negedge clk);
  endtask

  task automatic send_doc(input logic close);
    for (int i = 0; i < doc_q.size(); i++)
      send_byte(doc_q[i], close && (i == doc_q.size() - 1));
    doc_q.delete();
  endtask

  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [jkse_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [jkse_pkg::CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == jkse_pkg::ADDR_KEY_CHARS) key_chars = data;
    else if (addr == jkse_pkg::ADDR_KEY_LENGTH) key_len = data[jkse_pkg::KEY_LEN_W-1:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_key(input logic [jkse_pkg::KEY_W-1:0] chars,
                         input logic [jkse_pkg::KEY_LEN_W-1:0] len);
    settle_block();
    write_reg(jkse_pkg::ADDR_KEY_CHARS, chars);
    write_reg(jkse_pkg::ADDR_KEY_LENGTH, jkse_pkg::CFG_DATA_W'(len));
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] random_blank();
    logic [7:0] c;
    c = 8'($urandom_range(8'h0E, jkse_pkg::CHR_TAB));
    return (c == 8'h0E) ? jkse_pkg::CHR_SPACE : c;
  endfunction

  // Mostly well-formed documents around the current key, with some pure
  // noise, truncated documents and single corrupted bytes mixed in.
  function automatic void gen_doc();
    int unsigned k;
    int unsigned n;
    int unsigned pick;
    logic [7:0]  c;
    doc_q.delete();
    k    = (key_len > jkse_pkg::MAX_KEY_LEN) ? jkse_pkg::MAX_KEY_LEN : key_len;
    pick = $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(12, 1)) add_byte(8'($urandom_range(255)));
      return;
    end
    repeat ($urandom_range(3)) begin
      case ($urandom_range(3))
        0: add_byte("{");
        1: add_byte(jkse_pkg::CHR_SPACE);
        2: add_byte(jkse_pkg::CHR_QUOTE);
        default: add_byte(8'($urandom_range(255)));
      endcase
    end
    add_byte(jkse_pkg::CHR_QUOTE);
    for (int i = 0; i < k; i++) add_byte(key_chars[8*i +: 8]);
    add_byte(jkse_pkg::CHR_QUOTE);
    repeat ($urandom_range(2)) add_byte(random_blank());
    add_byte(($urandom_range(9) != 0) ? jkse_pkg::CHR_COLON : 8'($urandom_range(255)));
    repeat ($urandom_range(2)) add_byte(random_blank());
    add_byte(($urandom_range(9) != 0) ? jkse_pkg::CHR_QUOTE : 8'($urandom_range(255)));
    repeat ($urandom_range(10)) begin
      if ($urandom_range(3) == 0) begin
        add_byte(jkse_pkg::CHR_BSLASH);
        case ($urandom_range(8))
          0: c = jkse_pkg::CHR_LOW_B;
          1: c = jkse_pkg::CHR_LOW_F;
          2: c = jkse_pkg::CHR_LOW_N;
          3: c = jkse_pkg::CHR_LOW_R;
          4: c = jkse_pkg::CHR_LOW_T;
          5: c = jkse_pkg::CHR_QUOTE;
          6: c = jkse_pkg::CHR_BSLASH;
          7: c = "/";
          default: c = 8'($urandom_range(255));
        endcase
        add_byte(c);
      end else begin
        c = 8'($urandom_range(255));
        if (c == jkse_pkg::CHR_QUOTE || c == jkse_pkg::CHR_BSLASH) c = "A";
        add_byte(c);
      end
    end
    add_byte(jkse_pkg::CHR_QUOTE);
    repeat ($urandom_range(2)) add_byte(($urandom_range(1) != 0) ? "}" : ",");
    if (pick < 25) begin
      n = $urandom_range(doc_q.size(), 1);
      while (doc_q.size() > n) void'(doc_q.pop_back());
    end else if (pick < 35) begin
      doc_q[$urandom_range(doc_q.size() - 1)] = 8'($urandom_range(255));
    end
  endfunction

  task automatic run_docs(input int unsigned count);
    repeat (count) begin
      gen_doc();
      send_doc(1'b1);
    end
  endtask

  task automatic set_idling(input int unsigned sender_pct, input int unsigned stall_pct);
    sender_idle_pct = sender_pct;
    sink_stall_pct  = stall_pct;
  endtask

  // The empty key makes the needle two adjacent quotes, so each way a
  // document can end early takes only a few bytes.
  task automatic test_doc_end_cases();
    set_key('0, 4'd0);
    push_text("x");
    send_doc(1'b1);
    push_text("\"\"");
    send_doc(1'b1);
    push_text("\"\":");
    send_doc(1'b1);
    push_text("\"\": \"");
    send_doc(1'b1);
    push_text("\"\":1");
    send_doc(1'b1);
    push_text("\"\":\"\\");
    send_doc(1'b1);
    push_text("\"\":\"\\t\\");
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(jkse_pkg::CHR_QUOTE);
    send_doc(1'b1);
  endtask

  task automatic test_key_settings();
    set_key(64'h0000_0000_0062_3A61, 4'd3);
    push_text("{\"a:b\":\"v\"}");
    send_doc(1'b1);
    run_docs(3);
    set_key('1, 4'd8);
    run_docs(4);
    set_key('0, 4'd15);
    run_docs(4);
    set_key({$urandom, $urandom}, 4'd1);
    run_docs(4);
  endtask

  task automatic test_midstream_config();
    set_key(64'h0000_0000_0000_6261, 4'd2);
    push_text("{\"ab\":\"xy");
    send_doc(1'b0);
    set_key(64'h0000_0000_0000_007A, 4'd1);
    push_text("\\n\" , \"z\" : \"q\"}");
    send_doc(1'b1);
  endtask

  task automatic test_backpressure();
    set_key(64'h0000_0000_0000_006B, 4'd1);
    set_idling(0, 0);
    push_text("{\"k\":\"");
    repeat (40) add_byte(8'($urandom_range(8'h7E, 8'h5D)));
    add_byte(jkse_pkg::CHR_QUOTE);
    hold_req = 200;
    send_doc(1'b1);
  endtask

  task automatic test_random_docs();
    int unsigned                    sent;
    logic [jkse_pkg::KEY_LEN_W-1:0] len;
    logic [jkse_pkg::KEY_W-1:0]     chars;
    for (int mode = 0; mode < 4; mode++) begin
      for (int s = 0; s < 4; s++) begin
        case ($urandom_range(4))
          0: len = 4'd0;
          1: len = 4'd8;
          2: len = 4'($urandom_range(15, 9));
          default: len = 4'($urandom_range(8, 1));
        endcase
        case ($urandom_range(5))
          0: chars = '0;
          1: chars = '1;
          default: chars = {$urandom, $urandom};
        endcase
        set_key(chars, len);
        case (mode)
          0: set_idling(0, 0);
          1: set_idling(65, 0);
          2: set_idling(0, 65);
          default: set_idling(6, 6);
        endcase
        sent = 0;
        while (sent < 100) begin
          gen_doc();
          sent += doc_q.size();
          send_doc(1'b1);
        end
      end
    end
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = 8'h00;
    in_tlast        = 1'b0;
    out_tready      = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    mismatch_count  = 0;
    cycle_count     = 0;
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    hold_req        = 0;
    hold_left       = 0;
    key_chars       = '0;
    key_len         = 4'd1;
    rearm_scan();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_doc_end_cases();
    test_key_settings();
    test_midstream_config();
    test_backpressure();
    test_random_docs();
    settle_block();

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
